FILE: rtl/core/fbba_pkg.sv
// Shared types, constants and helper functions of the free block bitmap allocator.
// Used by the top level, the port checker and the testbench; depends on nothing.
package fbba_pkg;

    // Map geometry.
    localparam int MAP_BLOCKS      = 4096;
    localparam int RESERVED_BLOCKS = 10;
    localparam int WORD_W          = 64;
    localparam int NUM_WORDS       = MAP_BLOCKS / WORD_W;
    localparam int WADDR_W         = $clog2(NUM_WORDS);
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int IDX_W           = WADDR_W + BIT_W;
    localparam int GRP_W           = 8;
    localparam int NUM_GRPS        = WORD_W / GRP_W;
    localparam int GSEL_W          = $clog2(NUM_GRPS);
    localparam int BSEL_W          = $clog2(GRP_W);

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_FIND = 2'd0,
        REQ_USED = 2'd1,
        REQ_FREE = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ENC,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } t_state;

    // Formatted contents of one map word: bit i covers block w*WORD_W+i, 1 means free.
    function automatic logic [WORD_W-1:0] reset_word(input logic [WADDR_W-1:0] w);
        logic [WORD_W-1:0] v;
        v = '0;
        for (int i = 0; i < WORD_W; i++) begin
            v[i] = ((int'(w) * WORD_W + i) >= RESERVED_BLOCKS);
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/fbba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the free block map; no package dependency.
module fbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/free_block_bitmap_allocator.sv
// Top level of the free block bitmap allocator: request sequencer, map memory, encoder.
// Depends on fbba_pkg and fbba_ram.
//
//  Channel   Direction  Signals                         Contents
//  s         in         i_s_tvalid/o_s_tready           tdata: block_index; tuser: req_type
//  m         out        o_m_tvalid/i_m_tready           tdata: free_block; tuser: none_free
//
// A find reads the map one 64-bit word per cycle through the memory read port.
// A mark request is a read-modify-write of one word.
// Reset clears the per-word valid bits; a word that was never written reads as
// its formatted value, so no clearing pass is needed and requests start at once.
// A new request is taken while the previous result waits in the output register;
// the sequencer holds in its last state while that register is still occupied.
module free_block_bitmap_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fbba_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [11:0] block_index, [15:12] zero
    input  logic [fbba_pkg::S_TUSER_W-1:0]     i_s_tuser,  // [1:0] req_type
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fbba_pkg::M_TDATA_W-1:0]     o_m_tdata,  // [11:0] free_block, [15:12] zero
    output logic [fbba_pkg::M_TUSER_W-1:0]     o_m_tuser   // [0] none_free
);

    fbba_pkg::t_state                     r_state;
    fbba_pkg::t_state                     n_state;
    fbba_pkg::t_req                       r_req;
    logic [fbba_pkg::IDX_W-1:0]           r_idx;
    logic [fbba_pkg::WADDR_W-1:0]         r_addr;
    logic [fbba_pkg::WADDR_W-1:0]         r_chk;
    logic                                 r_pend;
    logic [fbba_pkg::NUM_WORDS-1:0]       r_valid;
    logic [fbba_pkg::WORD_W-1:0]          r_word;
    logic [fbba_pkg::IDX_W-1:0]           r_res_free;
    logic                                 r_res_none;
    logic                                 r_oval;
    logic [fbba_pkg::IDX_W-1:0]           r_ofree;
    logic                                 r_onone;

    logic                                 s_acc;
    logic                                 out_free;
    logic                                 finish;
    logic                                 word_nz;
    logic [fbba_pkg::WORD_W-1:0]          rd_data;
    logic [fbba_pkg::WORD_W-1:0]          eff_word;
    logic [fbba_pkg::WORD_W-1:0]          mod_word;
    logic                                 ram_we;
    logic [fbba_pkg::WADDR_W-1:0]         ram_raddr;
    logic [fbba_pkg::GSEL_W-1:0]          grp_sel;
    logic [fbba_pkg::BSEL_W-1:0]          bit_sel;
    logic [fbba_pkg::GRP_W-1:0]           grp_byte;

    // Map memory: one word per 64 blocks.
    fbba_ram #(
        .WIDTH (fbba_pkg::WORD_W),
        .DEPTH (fbba_pkg::NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_chk),
        .i_wdata (mod_word),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Handshake terms.
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_oval || i_m_tready;
    assign finish   = (r_state == fbba_pkg::ST_FINISH) && out_free;

    // A word never written since reset still holds its formatted value.
    assign eff_word = r_valid[r_chk] ? rd_data : fbba_pkg::reset_word(r_chk);
    assign word_nz  = |eff_word;

    // Set or clear the addressed block's bit for a mark request.
    always_comb begin
        mod_word = eff_word;
        mod_word[r_idx[fbba_pkg::BIT_W-1:0]] = (r_req == fbba_pkg::REQ_FREE);
    end

    // Two-level find-first-set over the captured word: first the group, then the bit.
    always_comb begin
        grp_sel = '0;
        bit_sel = '0;
        for (int g = fbba_pkg::NUM_GRPS - 1; g >= 0; g--) begin
            if (|r_word[g*fbba_pkg::GRP_W +: fbba_pkg::GRP_W]) begin
                grp_sel = fbba_pkg::GSEL_W'(g);
            end
        end
        grp_byte = r_word[grp_sel*fbba_pkg::GRP_W +: fbba_pkg::GRP_W];
        for (int j = fbba_pkg::GRP_W - 1; j >= 0; j--) begin
            if (grp_byte[j]) begin
                bit_sel = fbba_pkg::BSEL_W'(j);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fbba_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (fbba_pkg::t_req'(i_s_tuser))
                        fbba_pkg::REQ_FIND: n_state = fbba_pkg::ST_SCAN;
                        fbba_pkg::REQ_USED: n_state = fbba_pkg::ST_MARK_RD;
                        fbba_pkg::REQ_FREE: n_state = fbba_pkg::ST_MARK_RD;
                        default:            n_state = fbba_pkg::ST_FINISH;
                    endcase
                end
            end
            fbba_pkg::ST_SCAN: begin
                if (r_pend && word_nz) begin
                    n_state = fbba_pkg::ST_ENC;
                end else if (r_pend && (r_chk == fbba_pkg::LAST_WORD)) begin
                    n_state = fbba_pkg::ST_FINISH;
                end
            end
            fbba_pkg::ST_ENC:     n_state = fbba_pkg::ST_FINISH;
            fbba_pkg::ST_MARK_RD: n_state = fbba_pkg::ST_MARK_WR;
            fbba_pkg::ST_MARK_WR: n_state = fbba_pkg::ST_FINISH;
            fbba_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = fbba_pkg::ST_IDLE;
                end
            end
            default: n_state = fbba_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory controls and input ready.
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = r_addr;
        case (r_state)
            fbba_pkg::ST_IDLE:    o_s_tready = 1'b1;
            fbba_pkg::ST_SCAN:    ram_raddr  = r_addr;
            fbba_pkg::ST_MARK_RD: ram_raddr  = r_idx[fbba_pkg::IDX_W-1:fbba_pkg::BIT_W];
            fbba_pkg::ST_MARK_WR: ram_we     = 1'b1;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbba_pkg::ST_IDLE;
            r_valid <= '0;
            r_oval  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[r_chk] <= 1'b1;
            end
            if (finish) begin
                r_oval <= 1'b1;
            end else if (i_m_tready) begin
                r_oval <= 1'b0;
            end
            if (s_acc) begin
                r_pend <= 1'b0;
            end else if (r_state == fbba_pkg::ST_SCAN) begin
                r_pend <= 1'b1;
            end
        end
    end

    // Request capture, scan pointers and result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            fbba_pkg::ST_IDLE: begin
                if (s_acc) begin
                    r_req      <= fbba_pkg::t_req'(i_s_tuser);
                    r_idx      <= i_s_tdata[fbba_pkg::IDX_W-1:0];
                    r_addr     <= '0;
                    r_res_free <= '0;
                    r_res_none <= 1'b0;
                end
            end
            fbba_pkg::ST_SCAN: begin
                if (r_pend && word_nz) begin
                    r_word <= eff_word;
                end else begin
                    r_chk  <= r_addr;
                    r_addr <= r_addr + 1'b1;
                    if (r_pend && (r_chk == fbba_pkg::LAST_WORD)) begin
                        r_res_none <= 1'b1;
                    end
                end
            end
            fbba_pkg::ST_ENC: begin
                r_res_free <= {r_chk, grp_sel, bit_sel};
            end
            fbba_pkg::ST_MARK_RD: begin
                r_chk <= r_idx[fbba_pkg::IDX_W-1:fbba_pkg::BIT_W];
            end
            default: begin
                r_word <= r_word;
            end
        endcase
        if (finish) begin
            r_ofree <= r_res_free;
            r_onone <= r_res_none;
        end
    end

    // Result stream.
    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = fbba_pkg::M_TDATA_W'(r_ofree);
    assign o_m_tuser  = r_onone;

endmodule

FILE: rtl/core/fbba_checker.sv
// Port-level checker for the free block bitmap allocator, bound to the top level.
// Depends on fbba_pkg for the payload widths.
module fbba_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [fbba_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [fbba_pkg::M_TUSER_W-1:0] o_m_tuser
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result transfer dropped while stalled");

    // An empty-map answer carries block number zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("none_free result with nonzero block number");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while another is in progress");

    // No result right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

    // A result never follows its own request in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result appeared too early");

endmodule

bind free_block_bitmap_allocator fbba_checker u_fbba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of free_block_bitmap_allocator: directed requests, a fill of the
// low part of the map, then random allocate/release traffic under idling. Depends on fbba_pkg
// and the RTL.
module testbench;

    localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 180;
    localparam int FILL_BLOCKS  = 1024;  // blocks marked used one by one in the fill test
    localparam int MAX_REPORTS  = 10;

    // One answer of the allocator as it leaves on the master side.
    typedef struct packed {
        logic [fbba_pkg::IDX_W-1:0] free_block;
        logic                       none_free;
    } t_answer;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [fbba_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;  // [11:0] block_index, [15:12] zero
    logic [fbba_pkg::S_TUSER_W-1:0] i_s_tuser  = '0;  // [1:0] req_type
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [fbba_pkg::M_TDATA_W-1:0] o_m_tdata;        // [11:0] free_block, [15:12] zero
    logic [fbba_pkg::M_TUSER_W-1:0] o_m_tuser;        // [0] none_free

    // Shadow copy of the free map: bit b is set while block b is free.
    logic [fbba_pkg::MAP_BLOCKS-1:0] blk_free;
    t_answer                         answer_q[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int idle_cycles   = 0;
    int n_errors      = 0;
    int n_checked     = 0;
    int n_find        = 0;
    int n_full        = 0;
    int n_mark        = 0;
    int n_unknown     = 0;

    free_block_bitmap_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Updates the shadow map for one accepted request and works out the answer it must get.
    task automatic predict_answer(input fbba_pkg::t_req rq,
                                  input logic [fbba_pkg::IDX_W-1:0] idx,
                                  output t_answer ans);
        ans = '0;
        case (rq)
            fbba_pkg::REQ_FIND: begin
                n_find++;
                ans.none_free = 1'b1;
                for (int b = 0; b < fbba_pkg::MAP_BLOCKS; b++) begin
                    if (blk_free[b]) begin
                        ans.free_block = fbba_pkg::IDX_W'(b);
                        ans.none_free  = 1'b0;
                        break;
                    end
                end
                if (ans.none_free) n_full++;
            end
            fbba_pkg::REQ_USED: begin
                n_mark++;
                blk_free[idx] = 1'b0;
            end
            fbba_pkg::REQ_FREE: begin
                n_mark++;
                blk_free[idx] = 1'b1;
            end
            default: n_unknown++;
        endcase
    endtask

    // Sends one request, honoring the sender idle rate, and queues its answer once accepted.
    // Called and returning at a falling edge; tvalid stays high into the next call.
    task automatic send_req(input fbba_pkg::t_req rq, input logic [fbba_pkg::IDX_W-1:0] idx,
                            output t_answer ans);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= fbba_pkg::S_TDATA_W'(idx);
        i_s_tuser  <= rq;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_answer(rq, idx, ans);
        answer_q.push_back(ans);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Result checker: every transfer on the master side against the oldest pending answer.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_checked++;
            if (answer_q.size() == 0) begin
                report_mismatch("result with no request pending", 0, int'(o_m_tdata));
            end else begin
                want = answer_q.pop_front();
                if (o_m_tdata[fbba_pkg::IDX_W-1:0] !== want.free_block)
                    report_mismatch("free_block", int'(want.free_block),
                                    int'(o_m_tdata[fbba_pkg::IDX_W-1:0]));
                if (o_m_tuser[0] !== want.none_free)
                    report_mismatch("none_free", int'(want.none_free), int'(o_m_tuser[0]));
            end
        end
    end

    // Watchdog on cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer in %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Finds on the formatted map, and marks around the reserved blocks.
    task automatic test_formatted_map();
        t_answer ans;
        send_req(fbba_pkg::REQ_FIND, '0, ans);
        send_req(fbba_pkg::REQ_USED, fbba_pkg::IDX_W'(fbba_pkg::RESERVED_BLOCKS), ans);
        send_req(fbba_pkg::REQ_FIND, '0, ans);
        send_req(fbba_pkg::REQ_FREE, fbba_pkg::IDX_W'(fbba_pkg::RESERVED_BLOCKS - 1), ans);
        send_req(fbba_pkg::REQ_FIND, '1, ans);
        send_req(fbba_pkg::REQ_FREE, '0, ans);
        send_req(fbba_pkg::REQ_FIND, '0, ans);
        send_req(fbba_pkg::REQ_USED, '0, ans);
        send_req(fbba_pkg::REQ_FIND, '0, ans);
    endtask

    // Index extremes, repeated marks and unknown requests, which must leave the map alone.
    task automatic test_edge_requests();
        t_answer ans;
        send_req(fbba_pkg::REQ_USED, '1, ans);
        send_req(fbba_pkg::REQ_FREE, '1, ans);
        send_req(fbba_pkg::REQ_FREE, 12'h800, ans);
        send_req(fbba_pkg::REQ_USED, 12'h014, ans);
        send_req(fbba_pkg::REQ_USED, 12'h014, ans);
        send_req(fbba_pkg::REQ_NONE, '0, ans);
        send_req(fbba_pkg::REQ_NONE, '1, ans);
        send_req(fbba_pkg::REQ_NONE, 12'h555, ans);
        send_req(fbba_pkg::REQ_FIND, 12'hAAA, ans);
        send_req(fbba_pkg::REQ_USED, fbba_pkg::IDX_W'(fbba_pkg::RESERVED_BLOCKS - 1), ans);
        send_req(fbba_pkg::REQ_FREE, fbba_pkg::IDX_W'(fbba_pkg::RESERVED_BLOCKS), ans);
        send_req(fbba_pkg::REQ_FIND, '0, ans);
    endtask

    // Marks the low blocks used in order with a find after each 64 blocks, so finds walk
    // across many memory words, then frees and reclaims a block inside the filled region.
    task automatic test_map_fill();
        t_answer ans;
        for (int b = 0; b < FILL_BLOCKS; b++) begin
            send_req(fbba_pkg::REQ_USED, fbba_pkg::IDX_W'(b), ans);
            if (b % fbba_pkg::WORD_W == fbba_pkg::WORD_W - 1)
                send_req(fbba_pkg::REQ_FIND, fbba_pkg::IDX_W'(b), ans);
        end
        send_req(fbba_pkg::REQ_FIND, '1, ans);
        send_req(fbba_pkg::REQ_FREE, 12'h1F4, ans);
        send_req(fbba_pkg::REQ_FIND, '0, ans);
        send_req(fbba_pkg::REQ_USED, 12'h1F4, ans);
        send_req(fbba_pkg::REQ_FREE, '1, ans);
        send_req(fbba_pkg::REQ_USED, '1, ans);
        send_req(fbba_pkg::REQ_FIND, '0, ans);
    endtask

    // Allocator-style traffic: a find mostly followed by marking the found block used,
    // mixed with releases, stray marks and unknown requests.
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int items);
        t_answer                    ans;
        logic [fbba_pkg::IDX_W-1:0] found;
        int                         pick;
        int                         sent;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_req(fbba_pkg::REQ_FIND,
                         fbba_pkg::IDX_W'($urandom_range(fbba_pkg::MAP_BLOCKS - 1)), ans);
                sent++;
                if (!ans.none_free && $urandom_range(99) < 70) begin
                    found = ans.free_block;
                    send_req(fbba_pkg::REQ_USED, found, ans);
                    sent++;
                end
            end else if (pick < 62) begin
                send_req(fbba_pkg::REQ_FREE,
                         fbba_pkg::IDX_W'($urandom_range(fbba_pkg::MAP_BLOCKS - 1)), ans);
                sent++;
            end else if (pick < 70) begin
                // Releases near the start of the map keep the first two words busy.
                send_req(fbba_pkg::REQ_FREE,
                         fbba_pkg::IDX_W'($urandom_range(2 * fbba_pkg::WORD_W - 1)), ans);
                sent++;
            end else if (pick < 93) begin
                send_req(fbba_pkg::REQ_USED,
                         fbba_pkg::IDX_W'($urandom_range(fbba_pkg::MAP_BLOCKS - 1)), ans);
                sent++;
            end else begin
                send_req(fbba_pkg::REQ_NONE,
                         fbba_pkg::IDX_W'($urandom_range(fbba_pkg::MAP_BLOCKS - 1)), ans);
                sent++;
            end
        end
    endtask

    // Test sequence.
    initial begin
        for (int b = 0; b < fbba_pkg::MAP_BLOCKS; b++)
            blk_free[b] = (b >= fbba_pkg::RESERVED_BLOCKS);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_formatted_map();
        test_edge_requests();
        test_map_fill();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(73, 0, PHASE_ITEMS);
        test_random_traffic(0, 73, PHASE_ITEMS);
        test_random_traffic(38, 38, PHASE_ITEMS);
        i_s_tvalid <= 1'b0;

        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d finds (%0d on a full map), %0d marks, %0d unknown.",
                 n_checked, n_find, n_full, n_mark, n_unknown);
        $display("Low map region filled block by block, then random allocation under four "
                 , "idling mixes.");
        if (n_errors == 0 && answer_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d answers outstanding", n_errors, answer_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fbba_pkg.sv
rtl/core/fbba_ram.sv
rtl/core/free_block_bitmap_allocator.sv
rtl/core/fbba_checker.sv
dv/testbench.sv
